// ===== src/desa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desa_pkg: shared types and codes of the double-ended stack allocator
// Field widths, command, tier, status and register codes, and the control
// word that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package desa_pkg;

	// Default width of sizes and marks
	localparam int SIZE_BITS_DEF = 32;

	// Field widths of the channels
	localparam int CMD_W      = 4;
	localparam int NUM_W      = 32;
	localparam int TIER_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int OFFSET_W   = 33;
	localparam int FREE_W     = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC_PRI   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR_PRI   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_FREE_FRONT  = 4'd2;
	localparam logic [CMD_W-1:0] CMD_FREE_REAR   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_FREE_GLOBAL = 4'd4;
	localparam logic [CMD_W-1:0] CMD_SET_TIER    = 4'd5;
	localparam logic [CMD_W-1:0] CMD_ALLOC_CUR   = 4'd6;
	localparam logic [CMD_W-1:0] CMD_ALLOC_NEXT  = 4'd7;
	localparam logic [CMD_W-1:0] CMD_CLEAR_FRAME = 4'd8;
	localparam logic [CMD_W-1:0] CMD_SWAP        = 4'd9;

	// Primary tiers
	localparam logic [TIER_W-1:0] TIER_GLOBAL = 2'd0;
	localparam logic [TIER_W-1:0] TIER_FRONT  = 2'd1;
	localparam logic [TIER_W-1:0] TIER_REAR   = 2'd2;

	// Frame sides
	localparam logic SIDE_FRONT = 1'b0;
	localparam logic SIDE_REAR  = 1'b1;

	// Result status
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOCFG   = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRIMARY_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE   = 1'd1;

	// Controller to datapath commands
	typedef struct packed {
		logic exec;    // execute the accepted command word, load the result
		logic cfg_we;  // write a size register
	} ctl_t;

endpackage

// ===== src/desa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desa_if: channel interfaces of the double-ended stack allocator
// Command channel, result channel and configuration write channel, each
// with valid, ready and its payload.
// ----------------------------------------------------------------------------
interface desa_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [desa_pkg::CMD_W-1:0]   command;
	logic [desa_pkg::NUM_W-1:0]   num_bytes;
	logic [desa_pkg::TIER_W-1:0]  tier;

	modport source (output valid, output command, output num_bytes, output tier,
		input ready);
	modport sink (input valid, input command, input num_bytes, input tier,
		output ready);
endinterface

interface desa_res_if;
	logic                           valid;
	logic                           ready;
	logic [desa_pkg::STATUS_W-1:0]  status;
	logic [desa_pkg::OFFSET_W-1:0]  offset;
	logic [desa_pkg::FREE_W-1:0]    primary_free;
	logic [desa_pkg::FREE_W-1:0]    frame_free;

	modport source (output valid, output status, output offset, output primary_free,
		output frame_free, input ready);
	modport sink (input valid, input status, input offset, input primary_free,
		input frame_free, output ready);
endinterface

interface desa_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [desa_pkg::CFG_IDX_W-1:0]   index;
	logic [desa_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/double_ended_stack_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_stack_allocator_core: offset allocator for two stacks
// Top level joining the handshake controller and the allocator datapath.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command word (command, num_bytes, tier); res returns
//   exactly one result word (status, offset, primary_free, frame_free) per
//   command, in order. cfg writes primary_size (index 0) or frame_size
//   (index 1); a write resets that stack's marks. cfg is always ready. Write
//   cfg only while no command is in flight; the block does not enforce it.
//   Latency: the result word is valid the cycle after its command is
//   accepted. Throughput: one command per cycle, set by the single
//   compare/add on the mark registers and the one-deep result register.
//   When the receiver stalls, the result word holds and cmd.ready stays low
//   until it is taken; a word is accepted in the same cycle the waiting
//   result drains.
//   Reset: both sizes are zero (not configured), all marks zero, primary
//   tier global, frame side front, no result pending.
// ----------------------------------------------------------------------------
module double_ended_stack_allocator_core #(
	parameter int SIZE_BITS = desa_pkg::SIZE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	desa_cmd_if.sink   cmd,
	desa_res_if.source res,
	desa_cfg_if.sink   cfg
);

	desa_pkg::ctl_t ctl;

	// Handshake controller
	desa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.ctl       (ctl)
	);

	// Marks, sizes and result register
	desa_dp #(
		.SIZE_BITS (SIZE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.command      (cmd.command),
		.num_bytes    (cmd.num_bytes),
		.tier         (cmd.tier),
		.status       (res.status),
		.offset       (res.offset),
		.primary_free (res.primary_free),
		.frame_free   (res.frame_free)
	);

endmodule

// ===== src/desa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desa_ctrl: handshake controller
// Tracks whether the result register holds a word, accepts a command word
// whenever that register is empty or being drained, and issues the execute
// and register write commands to the datapath.
// ----------------------------------------------------------------------------
module desa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	output desa_pkg::ctl_t ctl
);

	localparam logic ST_EMPTY = 1'b0;
	localparam logic ST_FULL  = 1'b1;

	logic state_q;
	logic state_d;

	// Accept a word when the result register is free or drains this cycle
	assign in_ready  = (state_q == ST_EMPTY) || out_ready;
	assign out_valid = (state_q == ST_FULL);
	assign cfg_ready = 1'b1;

	assign ctl.exec   = in_valid && in_ready;
	assign ctl.cfg_we = cfg_valid;

	// Advance the result register occupancy
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_EMPTY: begin
				if (ctl.exec) state_d = ST_FULL;
			end
			ST_FULL: begin
				if (ctl.exec) state_d = ST_FULL;
				else if (out_ready) state_d = ST_EMPTY;
			end
			default: state_d = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_EMPTY;
		else state_q <= state_d;
	end

endmodule

// ===== src/desa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desa_dp: allocator datapath
// Size registers, primary and frame marks, the per-command next-state and
// result logic, and the result register.
// ----------------------------------------------------------------------------
module desa_dp #(
	parameter int SIZE_BITS = desa_pkg::SIZE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  desa_pkg::ctl_t                   ctl,
	input  logic [desa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [desa_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [desa_pkg::CMD_W-1:0]       command,
	input  logic [desa_pkg::NUM_W-1:0]       num_bytes,
	input  logic [desa_pkg::TIER_W-1:0]      tier,
	output logic [desa_pkg::STATUS_W-1:0]    status,
	output logic [desa_pkg::OFFSET_W-1:0]    offset,
	output logic [desa_pkg::FREE_W-1:0]      primary_free,
	output logic [desa_pkg::FREE_W-1:0]      frame_free
);

	localparam int OffW  = desa_pkg::OFFSET_W;
	localparam int FreeW = desa_pkg::FREE_W;

	typedef logic [SIZE_BITS-1:0] size_t;

	size_t                          psize_q, fsize_q;
	size_t                          global_q, front_q, rear_q;
	size_t                          ffront_q, frear_q;
	logic [desa_pkg::TIER_W-1:0]    tier_q;
	logic                           side_q;

	size_t                          global_d, front_d, rear_d;
	size_t                          ffront_d, frear_d;
	logic [desa_pkg::TIER_W-1:0]    tier_d;
	logic                           side_d;
	logic [desa_pkg::STATUS_W-1:0]  st_d;
	logic [SIZE_BITS:0]             off_d;

	size_t                          n;
	size_t                          cfg_val;
	size_t                          pri_room, glb_room, frm_room;
	logic                           alloc_side;

	assign n       = SIZE_BITS'(num_bytes);
	assign cfg_val = SIZE_BITS'(cfg_data);

	// Room left between the marks
	assign glb_room = rear_q - global_q;
	assign pri_room = rear_q - front_q;
	assign frm_room = frear_q - ffront_q;

	assign alloc_side = (command == desa_pkg::CMD_ALLOC_CUR) ? side_q : ~side_q;

	// Work out next marks and the result of one command word
	always_comb begin
		global_d = global_q;
		front_d  = front_q;
		rear_d   = rear_q;
		ffront_d = ffront_q;
		frear_d  = frear_q;
		tier_d   = tier_q;
		side_d   = side_q;
		st_d     = desa_pkg::ST_OK;
		off_d    = '0;
		case (command)
			desa_pkg::CMD_ALLOC_PRI: begin
				if (psize_q == '0) begin
					st_d = desa_pkg::ST_NOCFG;
				end else begin
					case (tier_q)
						desa_pkg::TIER_GLOBAL: begin
							if (n > glb_room) begin
								st_d = desa_pkg::ST_NOSPACE;
							end else begin
								off_d    = {1'b0, global_q};
								global_d = global_q + n;
								front_d  = global_q + n;
							end
						end
						desa_pkg::TIER_FRONT: begin
							if (n > pri_room) begin
								st_d = desa_pkg::ST_NOSPACE;
							end else begin
								off_d   = {1'b0, front_q};
								front_d = front_q + n;
							end
						end
						default: begin
							if (n > pri_room) begin
								st_d = desa_pkg::ST_NOSPACE;
							end else begin
								rear_d = rear_q - n;
								off_d  = {1'b0, rear_q - n};
							end
						end
					endcase
				end
			end
			desa_pkg::CMD_CLEAR_PRI: begin
				global_d = '0;
				front_d  = '0;
				rear_d   = psize_q;
			end
			desa_pkg::CMD_FREE_FRONT: begin
				front_d = global_q;
			end
			desa_pkg::CMD_FREE_REAR: begin
				rear_d = psize_q;
			end
			desa_pkg::CMD_FREE_GLOBAL: begin
				front_d = global_q;
				rear_d  = psize_q;
			end
			desa_pkg::CMD_SET_TIER: begin
				// Drop an unknown tier code
				if (tier inside {desa_pkg::TIER_GLOBAL, desa_pkg::TIER_FRONT,
						desa_pkg::TIER_REAR}) begin
					tier_d = tier;
					if (tier == desa_pkg::TIER_GLOBAL) front_d = global_q;
				end
			end
			desa_pkg::CMD_ALLOC_CUR, desa_pkg::CMD_ALLOC_NEXT: begin
				if (fsize_q == '0) begin
					st_d = desa_pkg::ST_NOCFG;
				end else if (n > frm_room) begin
					st_d = desa_pkg::ST_NOSPACE;
				end else if (alloc_side == desa_pkg::SIDE_FRONT) begin
					off_d    = {1'b0, psize_q} + {1'b0, ffront_q};
					ffront_d = ffront_q + n;
				end else begin
					frear_d = frear_q - n;
					off_d   = {1'b0, psize_q} + {1'b0, frear_q - n};
				end
			end
			desa_pkg::CMD_CLEAR_FRAME: begin
				ffront_d = '0;
				frear_d  = fsize_q;
			end
			desa_pkg::CMD_SWAP: begin
				// Wipe the current side and flip to the other one
				if (fsize_q != '0) begin
					if (side_q == desa_pkg::SIDE_FRONT) begin
						ffront_d = '0;
						side_d   = desa_pkg::SIDE_REAR;
					end else begin
						frear_d = fsize_q;
						side_d  = desa_pkg::SIDE_FRONT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the sizes and marks; a size write resets its stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psize_q  <= '0;
			fsize_q  <= '0;
			global_q <= '0;
			front_q  <= '0;
			rear_q   <= '0;
			tier_q   <= desa_pkg::TIER_GLOBAL;
			ffront_q <= '0;
			frear_q  <= '0;
			side_q   <= desa_pkg::SIDE_FRONT;
		end else if (ctl.cfg_we) begin
			case (cfg_index)
				desa_pkg::REG_PRIMARY_SIZE: begin
					psize_q  <= cfg_val;
					global_q <= '0;
					front_q  <= '0;
					rear_q   <= cfg_val;
					tier_q   <= desa_pkg::TIER_GLOBAL;
				end
				desa_pkg::REG_FRAME_SIZE: begin
					fsize_q  <= cfg_val;
					ffront_q <= '0;
					frear_q  <= cfg_val;
					side_q   <= desa_pkg::SIDE_FRONT;
				end
				default: begin
				end
			endcase
		end else if (ctl.exec) begin
			global_q <= global_d;
			front_q  <= front_d;
			rear_q   <= rear_d;
			tier_q   <= tier_d;
			ffront_q <= ffront_d;
			frear_q  <= frear_d;
			side_q   <= side_d;
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status       <= st_d;
			offset       <= OffW'(off_d);
			primary_free <= FreeW'(rear_d - front_d);
			frame_free   <= FreeW'(frear_d - ffront_d);
		end
	end

`ifndef SYNTHESIS
	a_pri_order: assert property (@(posedge clk) disable iff (!arst_n)
		(global_q <= front_q) && (front_q <= rear_q))
		else $error("primary marks out of order");
	a_pri_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |=> (rear_q <= psize_q))
		else $error("primary rear mark beyond primary size");
	a_frm_order: assert property (@(posedge clk) disable iff (!arst_n)
		(ffront_q <= frear_q) && (frear_q <= fsize_q))
		else $error("frame marks out of order");
`endif

endmodule

// ===== dv/desa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desa_checker: result predictor and scoreboard for the stack allocator
// Watches the command, result and configuration channels. Keeps its own copy
// of both stacks' sizes and marks, predicts one result word for each accepted
// command word, and compares every returned word field by field with the
// oldest prediction. Hands a failure count and the number of words still
// awaited to the testbench top.
// ----------------------------------------------------------------------------
module desa_checker #(
	parameter int SIZE_BITS = desa_pkg::SIZE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	desa_cmd_if  cmd,
	desa_res_if  res,
	desa_cfg_if  cfg,
	output int   mismatches,
	output int   pending_words
);
	import desa_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef logic [SIZE_BITS-1:0] mark_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFFSET_W-1:0] offset;
		logic [FREE_W-1:0]   primary_free;
		logic [FREE_W-1:0]   frame_free;
	} alloc_word_t;

	// Shadow copy of the allocator state
	mark_t             primary_size  = '0;
	mark_t             frame_size    = '0;
	mark_t             global_mark   = '0;
	mark_t             front_mark    = '0;
	mark_t             rear_mark     = '0;
	mark_t             fr_front_mark = '0;
	mark_t             fr_rear_mark  = '0;
	logic [TIER_W-1:0] primary_tier  = TIER_GLOBAL;
	logic              frame_side    = SIDE_FRONT;

	alloc_word_t expected_words[$];
	int          fail_total    = 0;
	int          words_waiting = 0;

	assign mismatches    = fail_total;
	assign pending_words = words_waiting;

	function automatic void restart_primary();
		global_mark  = '0;
		front_mark   = '0;
		rear_mark    = primary_size;
		primary_tier = TIER_GLOBAL;
	endfunction

	function automatic void restart_frame();
		fr_front_mark = '0;
		fr_rear_mark  = frame_size;
		frame_side    = SIDE_FRONT;
	endfunction

	// Carve n bytes from the primary stack on the current tier
	function automatic logic [STATUS_W-1:0] primary_carve(input mark_t n,
			output logic [OFFSET_W-1:0] off);
		off = '0;
		if (primary_size == '0)
			return ST_NOCFG;
		case (primary_tier)
		TIER_GLOBAL: begin
			if (n > rear_mark - global_mark)
				return ST_NOSPACE;
			off = OFFSET_W'(global_mark);
			global_mark = global_mark + n;
			front_mark = global_mark;
		end
		TIER_FRONT: begin
			if (n > rear_mark - front_mark)
				return ST_NOSPACE;
			off = OFFSET_W'(front_mark);
			front_mark = front_mark + n;
		end
		default: begin
			if (n > rear_mark - front_mark)
				return ST_NOSPACE;
			rear_mark = rear_mark - n;
			off = OFFSET_W'(rear_mark);
		end
		endcase
		return ST_OK;
	endfunction

	// Carve n bytes from one side of the frame stack;
	// offsets follow the primary region
	function automatic logic [STATUS_W-1:0] frame_carve(input logic side,
			input mark_t n, output logic [OFFSET_W-1:0] off);
		logic [SIZE_BITS:0] wide;
		off = '0;
		if (frame_size == '0)
			return ST_NOCFG;
		if (n > fr_rear_mark - fr_front_mark)
			return ST_NOSPACE;
		if (side == SIDE_FRONT) begin
			wide = primary_size + fr_front_mark;
			fr_front_mark = fr_front_mark + n;
		end else begin
			fr_rear_mark = fr_rear_mark - n;
			wide = primary_size + fr_rear_mark;
		end
		off = OFFSET_W'(wide);
		return ST_OK;
	endfunction

	// Advance the shadow state by one command word and build its result word
	function automatic alloc_word_t predict_word(input logic [CMD_W-1:0] op,
			input logic [NUM_W-1:0] num, input logic [TIER_W-1:0] new_tier);
		alloc_word_t         w;
		mark_t               n;
		logic [OFFSET_W-1:0] off;
		n = num;
		off = '0;
		w.status = ST_OK;
		case (op)
		CMD_ALLOC_PRI:   w.status = primary_carve(n, off);
		CMD_CLEAR_PRI: begin
			global_mark = '0;
			front_mark = '0;
			rear_mark = primary_size;
		end
		CMD_FREE_FRONT:  front_mark = global_mark;
		CMD_FREE_REAR:   rear_mark = primary_size;
		CMD_FREE_GLOBAL: begin
			front_mark = global_mark;
			rear_mark = primary_size;
		end
		CMD_SET_TIER: begin
			// the reserved tier code leaves everything as it is
			if (new_tier <= TIER_REAR) begin
				primary_tier = new_tier;
				if (new_tier == TIER_GLOBAL)
					front_mark = global_mark;
			end
		end
		CMD_ALLOC_CUR:   w.status = frame_carve(frame_side, n, off);
		CMD_ALLOC_NEXT:  w.status = frame_carve(~frame_side, n, off);
		CMD_CLEAR_FRAME: begin
			fr_front_mark = '0;
			fr_rear_mark = frame_size;
		end
		CMD_SWAP: begin
			// wipe the current side and hand over to the other one
			if (frame_size != '0) begin
				if (frame_side == SIDE_FRONT) begin
					fr_front_mark = '0;
					frame_side = SIDE_REAR;
				end else begin
					fr_rear_mark = frame_size;
					frame_side = SIDE_FRONT;
				end
			end
		end
		default: ;
		endcase
		w.offset = (w.status == ST_OK) ? off : '0;
		w.primary_free = FREE_W'(rear_mark - front_mark);
		w.frame_free = FREE_W'(fr_rear_mark - fr_front_mark);
		return w;
	endfunction

	task automatic flag_word(input string what, input alloc_word_t want,
			input alloc_word_t got);
		if (fail_total < REPORT_LIMIT)
			$display({"%0t desa_checker: %s: expected status %0d offset 0x%0h",
				" pfree %0d ffree %0d, got status %0d offset 0x%0h pfree %0d ffree %0d"},
				$realtime, what, want.status, want.offset, want.primary_free,
				want.frame_free, got.status, got.offset, got.primary_free,
				got.frame_free);
		fail_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		alloc_word_t got;
		alloc_word_t want;
		if (!arst_n) begin
			primary_size = '0;
			frame_size = '0;
			restart_primary();
			restart_frame();
			expected_words.delete();
			words_waiting <= 0;
		end else begin
			// Retire the returned word against the oldest prediction
			if (res.valid && res.ready) begin
				got = {res.status, res.offset, res.primary_free, res.frame_free};
				if (expected_words.size() == 0) begin
					flag_word("result word with no command pending", '0, got);
				end else begin
					want = expected_words.pop_front();
					if (got.status !== want.status || got.offset !== want.offset ||
							got.primary_free !== want.primary_free ||
							got.frame_free !== want.frame_free)
						flag_word("result word mismatch", want, got);
				end
			end
			// Apply a size write: it restarts that stack
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_PRIMARY_SIZE) begin
					primary_size = cfg.data;
					restart_primary();
				end else begin
					frame_size = cfg.data;
					restart_frame();
				end
			end
			// Predict the result of an accepted command word
			if (cmd.valid && cmd.ready)
				expected_words.push_back(predict_word(cmd.command, cmd.num_bytes,
					cmd.tier));
			words_waiting <= expected_words.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench top of the double-ended stack allocator
// Drives command words and size writes, stalls the result channel at random,
// and gives the verdict from the checker's failure count. A short directed
// run covers every command and the corner cases of both stacks; random
// phases follow, each with its own pair of stack sizes.
// ----------------------------------------------------------------------------
module tb_top;
	import desa_pkg::*;

	localparam int LONG_HOLD_CYCLES = 80;
	localparam int MAX_BURST        = 17;
	localparam int PHASES           = 10;
	localparam int ITEMS_PER_PHASE  = 115;
	localparam int QUIET_FROM_PHASE = 8;
	localparam int TIMEOUT_NS       = 4_000_000;

	localparam logic [CMD_W-1:0]      CMD_UNUSED_LO = CMD_SWAP + 4'd1;
	localparam logic [CMD_W-1:0]      CMD_UNUSED_HI = '1;
	localparam logic [TIER_W-1:0]     TIER_RESERVED = '1;
	localparam logic [CFG_DATA_W-1:0] SIZE_MAX      = '1;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches;
	int   pending_words;

	// Idle control shared by both sides; zero odds means no idling
	int burst_odds = 0;
	int hold_reqs  = 0;
	int holds_done = 0;
	int hold_left  = 0;
	int stall_left = 0;

	logic [CFG_DATA_W-1:0] primary_cap = '0;
	logic [CFG_DATA_W-1:0] frame_cap   = '0;

	desa_cmd_if cmd();
	desa_res_if res();
	desa_cfg_if cfg();

	double_ended_stack_allocator_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res),
		.cfg(cfg)
	);

	desa_checker #(.SIZE_BITS(SIZE_BITS_DEF)) alloc_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res),
		.cfg(cfg),
		.mismatches(mismatches),
		.pending_words(pending_words)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb: failure");
		$finish;
	end

	// Result side: long hold on request, else random stall bursts
	initial begin
		res.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_done) begin
				holds_done = hold_reqs;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				res.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				res.ready <= 1'b0;
				stall_left--;
			end else if (burst_odds != 0 && $urandom_range(0, burst_odds) == 0) begin
				stall_left = $urandom_range(1, MAX_BURST) - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// Offer one command word, after an idle burst now and then, and hold it until taken
	task automatic issue(input logic [CMD_W-1:0] op, input logic [NUM_W-1:0] num,
			input logic [TIER_W-1:0] t);
		int gap;
		if (burst_odds != 0 && $urandom_range(0, burst_odds) == 0) begin
			gap = $urandom_range(1, MAX_BURST);
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.command <= op;
		cmd.num_bytes <= num;
		cmd.tier <= t;
		do @(posedge clk); while (!cmd.ready);
	endtask

	// Stop offering and wait until every predicted word has come back
	task automatic drain();
		cmd.valid <= 1'b0;
		do @(posedge clk); while (pending_words != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == REG_PRIMARY_SIZE)
			primary_cap = val;
		else
			frame_cap = val;
	endtask

	// Favor allocations so the stacks fill; frees and clears drain them
	function automatic logic [CMD_W-1:0] pick_command();
		int r;
		r = $urandom_range(0, 99);
		if (r < 24) return CMD_ALLOC_PRI;
		if (r < 40) return CMD_ALLOC_CUR;
		if (r < 52) return CMD_ALLOC_NEXT;
		if (r < 62) return CMD_SET_TIER;
		if (r < 67) return CMD_FREE_FRONT;
		if (r < 72) return CMD_FREE_REAR;
		if (r < 76) return CMD_FREE_GLOBAL;
		if (r < 79) return CMD_CLEAR_PRI;
		if (r < 82) return CMD_CLEAR_FRAME;
		if (r < 96) return CMD_SWAP;
		return CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
	endfunction

	// Sizes mostly a fraction of the stack, with edge values mixed in
	function automatic logic [NUM_W-1:0] pick_bytes(input logic [NUM_W-1:0] span);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return '0;
		if (r < 12) return '1;
		if (r < 20) return $urandom;
		if (r < 28) return span;
		if (r < 34) return span - NUM_W'($urandom_range(0, 3));
		return $urandom_range(0, span >> 3);
	endfunction

	task automatic random_item();
		logic [CMD_W-1:0]  op;
		logic [TIER_W-1:0] t;
		logic [NUM_W-1:0]  num;
		op = pick_command();
		if ($urandom_range(0, 9) == 0)
			t = TIER_RESERVED;
		else
			t = TIER_W'($urandom_range(TIER_GLOBAL, TIER_REAR));
		if (op == CMD_ALLOC_CUR || op == CMD_ALLOC_NEXT)
			num = pick_bytes(frame_cap);
		else if (op == CMD_ALLOC_PRI)
			num = pick_bytes(primary_cap);
		else
			num = $urandom;
		issue(op, num, t);
	endtask

	task automatic run_phase(input int p);
		logic [CFG_DATA_W-1:0] psz;
		logic [CFG_DATA_W-1:0] fsz;
		case (p)
		0: begin psz = 256; fsz = 128; end
		1: begin psz = SIZE_MAX; fsz = SIZE_MAX; end
		2: begin psz = '0; fsz = 1000; end
		3: begin psz = 5000; fsz = '0; end
		4: begin psz = 1; fsz = 1; end
		5: begin psz = $urandom_range(1, 4096); fsz = $urandom_range(1, 4096); end
		6: begin psz = $urandom; fsz = $urandom; end
		7: begin psz = SIZE_MAX; fsz = 64; end
		default: begin psz = $urandom_range(16, 600); fsz = $urandom_range(16, 600); end
		endcase
		write_reg(REG_PRIMARY_SIZE, psz);
		write_reg(REG_FRAME_SIZE, fsz);
		// no idling in calm phases and at the tail of the run
		if (p >= QUIET_FROM_PHASE || p % 4 == 3)
			burst_odds <= 0;
		else
			burst_odds <= $urandom_range(2, 12);
		for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
			// back up the block behind a long result stall, later let it run dry
			if ((p == 1 || p == 5) && i == 40)
				hold_reqs <= hold_reqs + 1;
			if ((p == 1 || p == 5) && i == 80)
				drain();
			random_item();
		end
	endtask

	initial begin
		cmd.valid = 1'b0;
		cmd.command = CMD_ALLOC_PRI;
		cmd.num_bytes = '0;
		cmd.tier = TIER_GLOBAL;
		cfg.valid = 1'b0;
		cfg.index = REG_PRIMARY_SIZE;
		cfg.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_odds <= 4;

		// Unconfigured stacks, swap with no frame stack, unused codes
		issue(CMD_ALLOC_PRI, 16, TIER_GLOBAL);
		issue(CMD_ALLOC_CUR, 8, TIER_GLOBAL);
		issue(CMD_SWAP, $urandom, TIER_REAR);
		issue(CMD_UNUSED_LO, '1, TIER_RESERVED);
		issue(CMD_UNUSED_HI, $urandom, TIER_FRONT);

		// Primary tiers, zero-byte and exact-fit allocations, every free
		write_reg(REG_PRIMARY_SIZE, 100);
		write_reg(REG_FRAME_SIZE, 64);
		issue(CMD_SET_TIER, $urandom, TIER_FRONT);
		issue(CMD_ALLOC_PRI, 10, TIER_GLOBAL);
		issue(CMD_SET_TIER, $urandom, TIER_REAR);
		issue(CMD_ALLOC_PRI, 20, TIER_GLOBAL);
		issue(CMD_ALLOC_PRI, 0, TIER_GLOBAL);
		issue(CMD_SET_TIER, $urandom, TIER_RESERVED);
		issue(CMD_SET_TIER, $urandom, TIER_GLOBAL);
		issue(CMD_ALLOC_PRI, 5, TIER_GLOBAL);
		issue(CMD_ALLOC_PRI, 76, TIER_GLOBAL);
		issue(CMD_ALLOC_PRI, 75, TIER_GLOBAL);
		issue(CMD_FREE_FRONT, $urandom, TIER_GLOBAL);
		issue(CMD_FREE_REAR, $urandom, TIER_GLOBAL);
		issue(CMD_FREE_GLOBAL, $urandom, TIER_GLOBAL);
		issue(CMD_CLEAR_PRI, $urandom, TIER_GLOBAL);

		// Frame sides, swaps and overflow of the frame stack
		issue(CMD_ALLOC_CUR, 8, TIER_GLOBAL);
		issue(CMD_ALLOC_NEXT, 8, TIER_GLOBAL);
		issue(CMD_SWAP, $urandom, TIER_GLOBAL);
		issue(CMD_ALLOC_CUR, 4, TIER_GLOBAL);
		issue(CMD_ALLOC_NEXT, 65, TIER_GLOBAL);
		issue(CMD_CLEAR_FRAME, $urandom, TIER_GLOBAL);
		issue(CMD_SWAP, $urandom, TIER_GLOBAL);

		// Largest sizes: full-stack allocation and the highest offset
		write_reg(REG_PRIMARY_SIZE, SIZE_MAX);
		write_reg(REG_FRAME_SIZE, SIZE_MAX);
		issue(CMD_ALLOC_PRI, '1, TIER_GLOBAL);
		issue(CMD_ALLOC_CUR, '1, TIER_GLOBAL);
		issue(CMD_ALLOC_CUR, 0, TIER_GLOBAL);

		for (int p = 0; p < PHASES; p++)
			run_phase(p);

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending_words == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
